[rtl/core/caldc_pkg.sv]
// calendar date counter: shared types, constants and the month length function
// used by the controller, the datapath and the top level; no dependencies

package caldc_pkg;

    // field widths of the transaction ports
    localparam int ACT_W   = 3;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int COUNT_W = 16;

    // calendar constants
    localparam logic [YEAR_W-1:0]  BASE_YEAR      = 12'd1900;
    localparam int                 YEAR_FIELD_TOP = 4095;
    localparam logic [MONTH_W-1:0] LAST_MONTH     = 4'd12;
    localparam logic [DAY_W-1:0]   LAST_DAY       = 5'd31;
    localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS  = 5'd29;

    localparam logic [DAY_W-1:0] MONTH_LEN [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_SET  = 3'd0,
        ACT_NEXT = 3'd1,
        ACT_PREV = 3'd2,
        ACT_ADD  = 3'd3,
        ACT_SUB  = 3'd4
    } t_action;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture input transaction
        logic do_set;   // write the requested date
        logic do_fwd;   // one day forward
        logic do_back;  // one day back
        logic dec;      // decrement remaining day count
        logic wr_ok;    // write ok flag
        logic ok_val;
        logic push;     // load output register from stored date
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        t_action act;
        logic    set_valid;
        logic    fwd_blocked;
        logic    back_blocked;
        logic    count_zero;
        logic    out_free;
    } t_dp_sts;

    // days in month m of year y, every fourth year leap
    function automatic logic [DAY_W-1:0] days_in(
        input logic [MONTH_W-1:0] m,
        input logic [YEAR_W-1:0]  y
    );
        logic [DAY_W-1:0] n;
        if (m < 4'd1 || m > LAST_MONTH) begin
            n = LAST_DAY;
        end else if (m == 4'd2 && y[1:0] == 2'b00) begin
            n = LEAP_FEB_DAYS;
        end else begin
            n = MONTH_LEN[4'(m - 4'd1)];
        end
        return n;
    endfunction

endpackage

[rtl/core/caldc_ctrl.sv]
// calendar date counter: controller state machine
// depends on caldc_pkg for the command, status and action types

module caldc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  caldc_pkg::t_dp_sts i_sts,
    output caldc_pkg::t_dp_cmd o_cmd
);
    import caldc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_PUSH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // one transaction in flight at a time
    assign o_stall = (r_state != ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.wr_ok  = 1'b1;
                o_cmd.ok_val = 1'b1;
                case (i_sts.act)
                    ACT_SET: begin
                        o_cmd.do_set = i_sts.set_valid;
                        o_cmd.ok_val = i_sts.set_valid;
                        n_state      = ST_PUSH;
                    end
                    ACT_NEXT: begin
                        o_cmd.do_fwd = 1'b1;
                        n_state      = ST_PUSH;
                    end
                    ACT_PREV: begin
                        o_cmd.do_back = 1'b1;
                        n_state       = ST_PUSH;
                    end
                    ACT_ADD: begin
                        if (i_sts.count_zero || i_sts.fwd_blocked) begin
                            n_state = ST_PUSH;
                        end else begin
                            o_cmd.do_fwd = 1'b1;
                            o_cmd.dec    = 1'b1;
                        end
                    end
                    ACT_SUB: begin
                        if (i_sts.count_zero || i_sts.back_blocked) begin
                            n_state = ST_PUSH;
                        end else begin
                            o_cmd.do_back = 1'b1;
                            o_cmd.dec     = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.ok_val = 1'b0;
                        n_state      = ST_PUSH;
                    end
                endcase
            end
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/caldc_dp.sv]
// calendar date counter: datapath with the stored date, day step unit,
// set check, remaining count and output register; depends on caldc_pkg

module caldc_dp #(
    parameter int MAX_YEAR = 4095
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [caldc_pkg::ACT_W-1:0]     i_action,
    input  logic [caldc_pkg::DAY_W-1:0]     i_day_in,
    input  logic [caldc_pkg::MONTH_W-1:0]   i_month_in,
    input  logic [caldc_pkg::YEAR_W-1:0]    i_year_in,
    input  logic [caldc_pkg::COUNT_W-1:0]   i_count,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [caldc_pkg::DAY_W-1:0]     o_day_out,
    output logic [caldc_pkg::MONTH_W-1:0]   o_month_out,
    output logic [caldc_pkg::YEAR_W-1:0]    o_year_out,
    output logic                            o_ok,
    input  caldc_pkg::t_dp_cmd              i_cmd,
    output caldc_pkg::t_dp_sts              o_sts
);
    import caldc_pkg::*;

    // top year clipped to the year field
    localparam logic [YEAR_W-1:0] TOP_YEAR =
        YEAR_W'((MAX_YEAR < YEAR_FIELD_TOP) ? MAX_YEAR : YEAR_FIELD_TOP);

    logic [DAY_W-1:0]   r_day,   n_day;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year,  n_year;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [ACT_W-1:0]   r_act;
    logic [DAY_W-1:0]   r_day_in;
    logic [MONTH_W-1:0] r_month_in;
    logic [YEAR_W-1:0]  r_year_in;
    logic               r_ok;

    logic               r_out_valid;
    logic [DAY_W-1:0]   r_out_day;
    logic [MONTH_W-1:0] r_out_month;
    logic [YEAR_W-1:0]  r_out_year;
    logic               r_out_ok;

    logic [DAY_W-1:0]   dim_cur;
    logic [DAY_W-1:0]   dim_prev;
    logic [DAY_W-1:0]   dim_set;
    logic [MONTH_W-1:0] prev_month;
    logic [DAY_W-1:0]   fwd_day,   back_day;
    logic [MONTH_W-1:0] fwd_month, back_month;
    logic [YEAR_W-1:0]  fwd_year,  back_year;
    logic               fwd_blocked, back_blocked;
    logic               set_valid;

    // month lengths for the step unit and the set check
    assign prev_month = r_month - 4'd1;
    assign dim_cur    = days_in(r_month, r_year);
    assign dim_prev   = days_in(prev_month, r_year);
    assign dim_set    = days_in(r_month_in, r_year_in);

    // one day forward
    always_comb begin
        fwd_day     = r_day;
        fwd_month   = r_month;
        fwd_year    = r_year;
        fwd_blocked = 1'b0;
        if (r_day < dim_cur) begin
            fwd_day = r_day + 5'd1;
        end else if (r_month < LAST_MONTH) begin
            fwd_month = r_month + 4'd1;
            fwd_day   = 5'd1;
        end else if (r_year < TOP_YEAR) begin
            fwd_year  = r_year + 12'd1;
            fwd_month = 4'd1;
            fwd_day   = 5'd1;
        end else begin
            fwd_blocked = 1'b1;
        end
    end

    // one day back
    always_comb begin
        back_day     = r_day;
        back_month   = r_month;
        back_year    = r_year;
        back_blocked = 1'b0;
        if (r_day > 5'd1) begin
            back_day = r_day - 5'd1;
        end else if (r_month > 4'd1) begin
            back_month = prev_month;
            back_day   = dim_prev;
        end else if (r_year > BASE_YEAR) begin
            back_year  = r_year - 12'd1;
            back_month = LAST_MONTH;
            back_day   = LAST_DAY;
        end else begin
            back_blocked = 1'b1;
        end
    end

    // set request check
    assign set_valid = (r_day_in >= 5'd1) && (r_month_in >= 4'd1) &&
                       (r_month_in <= LAST_MONTH) && (r_year_in >= BASE_YEAR) &&
                       (r_year_in <= TOP_YEAR) && (r_day_in <= dim_set);

    // next stored date and count
    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        if (i_cmd.do_set) begin
            n_day   = r_day_in;
            n_month = r_month_in;
            n_year  = r_year_in;
        end else if (i_cmd.do_fwd) begin
            n_day   = fwd_day;
            n_month = fwd_month;
            n_year  = fwd_year;
        end else if (i_cmd.do_back) begin
            n_day   = back_day;
            n_month = back_month;
            n_year  = back_year;
        end
        n_count = r_count;
        if (i_cmd.load) begin
            n_count = i_count;
        end else if (i_cmd.dec) begin
            n_count = r_count - 16'd1;
        end
    end

    // stored date
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= 5'd1;
            r_month <= 4'd1;
            r_year  <= BASE_YEAR;
        end else begin
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
        end
    end

    // captured transaction fields, count and ok flag
    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        if (i_cmd.load) begin
            r_act      <= i_action;
            r_day_in   <= i_day_in;
            r_month_in <= i_month_in;
            r_year_in  <= i_year_in;
        end
        if (i_cmd.wr_ok) begin
            r_ok <= i_cmd.ok_val;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_day   <= r_day;
            r_out_month <= r_month;
            r_out_year  <= r_year;
            r_out_ok    <= r_ok;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_day_out   = r_out_day;
    assign o_month_out = r_out_month;
    assign o_year_out  = r_out_year;
    assign o_ok        = r_out_ok;

    // status to the controller
    assign o_sts.act          = t_action'(r_act);
    assign o_sts.set_valid    = set_valid;
    assign o_sts.fwd_blocked  = fwd_blocked;
    assign o_sts.back_blocked = back_blocked;
    assign o_sts.count_zero   = (r_count == '0);
    assign o_sts.out_free     = !r_out_valid || !i_stall;

endmodule

[rtl/core/calendar_date_counter_top.sv]
// Calendar date counter. Holds a day/month/year date (reset 1 Jan 1900, every
// fourth year leap) and per transaction sets it (checked; a bad date keeps
// the old one and returns ok = 0) or moves it by one day or by i_count days,
// clamped at 1 Jan 1900 and at 31 Dec of min(MAX_YEAR, 4095). An unused action
// code keeps the date and returns ok = 0. One result per transaction. Add and
// subtract run the shared day step unit one day per cycle until the count is
// used up or a date bound is reached.
// A result held by a stalled output adds its wait to the result stage only;
// the next transaction is taken as soon as the result is in the output register.
// depends on caldc_pkg, caldc_ctrl and caldc_dp

module calendar_date_counter_top #(
    parameter int MAX_YEAR = 4095
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [caldc_pkg::ACT_W-1:0]     i_action,
    input  logic [caldc_pkg::DAY_W-1:0]     i_day_in,
    input  logic [caldc_pkg::MONTH_W-1:0]   i_month_in,
    input  logic [caldc_pkg::YEAR_W-1:0]    i_year_in,
    input  logic [caldc_pkg::COUNT_W-1:0]   i_count,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [caldc_pkg::DAY_W-1:0]     o_day_out,
    output logic [caldc_pkg::MONTH_W-1:0]   o_month_out,
    output logic [caldc_pkg::YEAR_W-1:0]    o_year_out,
    output logic                            o_ok
);
    import caldc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    caldc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // date registers, step unit and output register
    caldc_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_action),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .i_count     (i_count),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out),
        .o_ok        (o_ok),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

[rtl/core/caldc_chk.sv]
// calendar date counter: port level checks and their bind to the top level
// depends only on the top level's ports

module caldc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [2:0]  i_action,
    input logic [4:0]  i_day_in,
    input logic [3:0]  i_month_in,
    input logic [11:0] i_year_in,
    input logic [15:0] i_count,
    input logic        o_valid,
    input logic        i_stall,
    input logic [4:0]  o_day_out,
    input logic [3:0]  o_month_out,
    input logic [11:0] o_year_out,
    input logic        o_ok
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_day_out) &&
        $stable(o_month_out) && $stable(o_year_out) && $stable(o_ok))
        else $error("stalled result changed");

    // reported date always has day 1 to 31, month 1 to 12 and year at least 1900
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_day_out >= 5'd1 && o_day_out <= 5'd31 &&
        o_month_out >= 4'd1 && o_month_out <= 4'd12 && o_year_out >= 12'd1900)
        else $error("result date out of range");

    // one transaction in flight: input stalls right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after transaction accepted");

    // a new result only appears while a transaction is in flight
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared with no transaction in flight");

endmodule

bind calendar_date_counter_top caldc_chk u_caldc_chk (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for calendar_date_counter_top: directed table, then random traffic,
// each result checked against a typed table expectation or an in-bench date predictor
// depends on caldc_pkg and calendar_date_counter_top

module testbench;
    import caldc_pkg::*;

    // year clamp is min(MAX_YEAR, 4095); the instance uses the full field
    localparam int TOP_YEAR     = 4095;
    localparam int RANDOM_ITEMS = 1400;
    // longest quiet stretch of a correct run is one add of 65535 days
    localparam int QUIET_LIMIT  = 200000;
    localparam int HOLDOFF_LEN  = 400;

    // action codes with no operation behind them
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
    } t_request;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               ok;
    } t_date_result;

    typedef struct packed {
        t_request     req;
        logic         typed;
        t_date_result want;
    } t_row;

    // directed table: typed expectations where the answer is obvious
    localparam t_row DIRECTED [0:24] = '{
        // bounds and zero count from the reset date
        '{'{ACT_PREV, 5'd0, 4'd0, 12'd0, 16'd0}, 1'b1, '{5'd1, 4'd1, 12'd1900, 1'b1}},
        '{'{ACT_SUB,  5'd0, 4'd0, 12'd0, 16'd5}, 1'b1, '{5'd1, 4'd1, 12'd1900, 1'b1}},
        '{'{ACT_ADD,  5'd0, 4'd0, 12'd0, 16'd0}, 1'b1, '{5'd1, 4'd1, 12'd1900, 1'b1}},
        '{'{ACT_NEXT, 5'd0, 4'd0, 12'd0, 16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b1}},
        '{'{ACT_SUB,  5'd0, 4'd0, 12'd0, 16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b1}},
        // rejected set requests keep the date
        '{'{ACT_SET, 5'd0,  4'd1,  12'd1900, 16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b0}},
        '{'{ACT_SET, 5'd1,  4'd0,  12'd1900, 16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b0}},
        '{'{ACT_SET, 5'd1,  4'd13, 12'd2000, 16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b0}},
        '{'{ACT_SET, 5'd1,  4'd15, 12'd2000, 16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b0}},
        '{'{ACT_SET, 5'd1,  4'd1,  12'd1899, 16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b0}},
        '{'{ACT_SET, 5'd1,  4'd1,  12'd0,    16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b0}},
        '{'{ACT_SET, 5'd31, 4'd4,  12'd2000, 16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b0}},
        '{'{ACT_SET, 5'd29, 4'd2,  12'd1901, 16'd0}, 1'b1, '{5'd2, 4'd1, 12'd1900, 1'b0}},
        // leap day, and no century exception
        '{'{ACT_SET, 5'd29, 4'd2, 12'd1904, 16'd0}, 1'b1, '{5'd29, 4'd2, 12'd1904, 1'b1}},
        '{'{ACT_NEXT, 5'd0, 4'd0, 12'd0, 16'd0},    1'b0, '0},
        '{'{ACT_PREV, 5'd0, 4'd0, 12'd0, 16'd0},    1'b0, '0},
        '{'{ACT_SET, 5'd29, 4'd2, 12'd2100, 16'd0}, 1'b1, '{5'd29, 4'd2, 12'd2100, 1'b1}},
        // upper bound
        '{'{ACT_SET, 5'd31, 4'd12, 12'd4095, 16'd0}, 1'b1, '{5'd31, 4'd12, 12'd4095, 1'b1}},
        '{'{ACT_NEXT, 5'd0, 4'd0, 12'd0, 16'd0},     1'b1, '{5'd31, 4'd12, 12'd4095, 1'b1}},
        '{'{ACT_ADD, 5'd0, 4'd0, 12'd0, 16'd65535},  1'b1, '{5'd31, 4'd12, 12'd4095, 1'b1}},
        '{'{ACT_SUB, 5'd0, 4'd0, 12'd0, 16'd1},      1'b0, '0},
        // unused action codes
        '{'{ACT_SPARE_FIRST, 5'd31, 4'd15, 12'd4095, 16'd65535}, 1'b0, '0},
        '{'{ACT_SPARE_LAST,  5'd0,  4'd0,  12'd0,    16'd0},     1'b0, '0},
        // lower bound with the largest count
        '{'{ACT_SET, 5'd1, 4'd1, 12'd1900, 16'd0},  1'b1, '{5'd1, 4'd1, 12'd1900, 1'b1}},
        '{'{ACT_SUB, 5'd0, 4'd0, 12'd0, 16'd65535}, 1'b1, '{5'd1, 4'd1, 12'd1900, 1'b1}}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [ACT_W-1:0]   i_action = '0;
    logic [DAY_W-1:0]   i_day_in = '0;
    logic [MONTH_W-1:0] i_month_in = '0;
    logic [YEAR_W-1:0]  i_year_in = '0;
    logic [COUNT_W-1:0] i_count = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [DAY_W-1:0]   o_day_out;
    logic [MONTH_W-1:0] o_month_out;
    logic [YEAR_W-1:0]  o_year_out;
    logic               o_ok;

    // predicted stored date
    logic [DAY_W-1:0]   cal_day = 5'd1;
    logic [MONTH_W-1:0] cal_month = 4'd1;
    logic [YEAR_W-1:0]  cal_year = 12'd1900;

    t_date_result pending_dates [$];
    int mismatches = 0;
    int burst_left = 0;
    int holdoff_requests = 0;
    int holdoffs_granted = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int quiet_cycles = 0;

    calendar_date_counter_top #(
        .MAX_YEAR(TOP_YEAR)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .i_count     (i_count),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out),
        .o_ok        (o_ok)
    );

    always #2 i_clk = ~i_clk;

    // days in a month, every fourth year leap; out-of-range months count 31
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] m,
        input logic [YEAR_W-1:0]  y
    );
        case (m)
            4'd2:                   return (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                return 5'd31;
        endcase
    endfunction

    // one day forward, false when held at the top date
    function automatic bit advance_day();
        if (cal_day < month_length(cal_month, cal_year)) begin
            cal_day++;
        end else if (cal_month < LAST_MONTH) begin
            cal_month++;
            cal_day = 5'd1;
        end else if (cal_year >= TOP_YEAR) begin
            return 1'b0;
        end else begin
            cal_year++;
            cal_month = 4'd1;
            cal_day = 5'd1;
        end
        return 1'b1;
    endfunction

    // one day back, false when held at 1 jan of the base year
    function automatic bit retreat_day();
        if (cal_day > 5'd1) begin
            cal_day--;
        end else if (cal_month > 4'd1) begin
            cal_month--;
            cal_day = month_length(cal_month, cal_year);
        end else if (cal_year <= BASE_YEAR) begin
            return 1'b0;
        end else begin
            cal_year--;
            cal_month = LAST_MONTH;
            cal_day = LAST_DAY;
        end
        return 1'b1;
    endfunction

    // apply one transaction to the predicted date and return the result
    function automatic t_date_result apply_request(input t_request r);
        t_date_result res;
        int unsigned left;
        res.ok = 1'b1;
        left = 32'(r.count);
        case (r.action)
            ACT_SET: begin
                if (r.day >= 5'd1 && r.month >= 4'd1 && r.month <= LAST_MONTH &&
                    r.year >= BASE_YEAR && r.year <= TOP_YEAR &&
                    r.day <= month_length(r.month, r.year)) begin
                    cal_day = r.day;
                    cal_month = r.month;
                    cal_year = r.year;
                end else begin
                    res.ok = 1'b0;
                end
            end
            ACT_NEXT: void'(advance_day());
            ACT_PREV: void'(retreat_day());
            ACT_ADD:  while (left != 0 && advance_day()) left--;
            ACT_SUB:  while (left != 0 && retreat_day()) left--;
            default:  res.ok = 1'b0;
        endcase
        res.day = cal_day;
        res.month = cal_month;
        res.year = cal_year;
        return res;
    endfunction

    // random transaction: mostly well-formed sets and short moves, some noise
    function automatic t_request pick_request();
        t_request r;
        int unsigned roll;
        logic [DAY_W-1:0] len;
        r.day = DAY_W'($urandom_range(0, 31));
        r.month = MONTH_W'($urandom_range(0, 15));
        r.year = YEAR_W'($urandom_range(0, 4095));
        r.count = COUNT_W'($urandom_range(0, 65535));
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            // valid date, often at a month end or near a bound
            r.action = ACT_SET;
            r.month = MONTH_W'($urandom_range(1, 12));
            case ($urandom_range(0, 5))
                0, 1, 2, 3: r.year = YEAR_W'($urandom_range(1900, 2040));
                4:          r.year = YEAR_W'($urandom_range(4085, TOP_YEAR));
                default:    r.year = YEAR_W'($urandom_range(1900, TOP_YEAR));
            endcase
            len = month_length(r.month, r.year);
            if ($urandom_range(0, 1) == 0)
                r.day = len - 5'($urandom_range(0, 1));
            else
                r.day = DAY_W'($urandom_range(1, len));
        end else if (roll < 20) begin
            r.action = ACT_SET;
        end else if (roll < 35) begin
            r.action = ACT_NEXT;
        end else if (roll < 50) begin
            r.action = ACT_PREV;
        end else if (roll < 96) begin
            r.action = (roll < 73) ? ACT_ADD : ACT_SUB;
            // the block walks one day per cycle, so long counts stay rare
            roll = $urandom_range(0, 99);
            if (roll == 0)
                r.count = COUNT_W'($urandom_range(0, 65535));
            else if (roll < 14)
                r.count = COUNT_W'($urandom_range(0, 2000));
            else
                r.count = COUNT_W'($urandom_range(0, 40));
        end else begin
            r.action = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
    endtask

    // present one transaction and hold it until taken
    task automatic offer(input t_request r, input logic typed, input t_date_result want);
        t_date_result predicted;
        i_valid <= 1'b1;
        i_action <= r.action;
        i_day_in <= r.day;
        i_month_in <= r.month;
        i_year_in <= r.year;
        i_count <= r.count;
        do @(posedge i_clk); while (o_stall);
        predicted = apply_request(r);
        pending_dates.push_back(typed ? want : predicted);
    endtask

    // burst pacing: either go straight on or drop valid for a random gap
    task automatic pace();
        int gap;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(10, 40);
            burst_left = $urandom_range(0, 24);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending until every result is back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_dates.size() != 0);
    endtask

    // sender
    initial begin : stimulus
        t_date_result none;
        none = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED[k]) begin
            offer(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].want);
            pace();
        end
        drain();
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // long receiver hold-off while the sender keeps pushing
            if (k == 500) begin
                holdoff_requests++;
                burst_left = 60;
            end
            offer(pick_request(), 1'b0, none);
            if (k == 1000)
                drain();
            else
                pace();
        end
        i_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("calendar_date_counter_top: match");
        else
            $display("calendar_date_counter_top: mismatch");
        $finish;
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (holdoffs_granted != holdoff_requests) begin
            holdoffs_granted++;
            hold_left = HOLDOFF_LEN;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 200);
            end
            mode_left--;
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ~i_stall;
                default: i_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        t_date_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("unrequested result, day", int'(o_day_out), 0);
            end else begin
                want = pending_dates.pop_front();
                if (o_day_out !== want.day)
                    report_mismatch("day", int'(o_day_out), int'(want.day));
                if (o_month_out !== want.month)
                    report_mismatch("month", int'(o_month_out), int'(want.month));
                if (o_year_out !== want.year)
                    report_mismatch("year", int'(o_year_out), int'(want.year));
                if (o_ok !== want.ok)
                    report_mismatch("ok", int'(o_ok), int'(want.ok));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("calendar_date_counter_top: mismatch");
            $finish;
        end
    end

endmodule

[files.f]
rtl/core/caldc_pkg.sv
rtl/core/caldc_ctrl.sv
rtl/core/caldc_dp.sv
rtl/core/calendar_date_counter_top.sv
rtl/core/caldc_chk.sv
bench/testbench.sv
